/* rtl/core/mfde_pkg.sv */
// Package for the monochrome framebuffer draw engine: command codes, states, defaults.
`timescale 1ns / 1ps
package mfde_pkg;

  // Default geometry
  localparam int DEF_SCREEN_WIDTH  = 128;
  localparam int DEF_SCREEN_HEIGHT = 64;
  localparam int DEF_STORE_BYTES   = 1024;

  // Width of a full byte address before range check: x < 256 plus (y/8 < 32) * width < 256
  localparam int FULL_ADDR_W = 14;

  // Command codes carried on func
  typedef enum logic [2:0] {
    FUNC_PIXEL = 3'd0,
    FUNC_HLINE = 3'd1,
    FUNC_VLINE = 3'd2,
    FUNC_RECT  = 3'd3,
    FUNC_FILL  = 3'd4,
    FUNC_CLEAR = 3'd5,
    FUNC_READ  = 3'd6,
    FUNC_NOP   = 3'd7
  } func_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_SEG,
    ST_PIX_RD,
    ST_PIX_WR,
    ST_READ,
    ST_READ_WAIT,
    ST_DONE
  } state_t;

endpackage

/* rtl/core/mono_framebuffer_draw_engine_top.sv */
// Top level of the monochrome framebuffer draw engine: sequencer, pixel RMW unit and store.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+--------------------------------------------
//  in      | input     | in_valid / in_ready  | func, x_first, y_first, x_second, y_second,
//          |           |                      | run_length, pixel_value, byte_index
//  out     | output    | out_valid / out_ready| read_data, command_done
//
// Every drawing command is broken into runs (segments); each pixel of a run is a store read,
// then a masked write, on the single store port; an off-screen pixel skips the write, and
// each segment has a setup state. A filled rectangle is w columns of h+1 pixels.
// Clear sweeps the store one byte a cycle. Read addresses the store, then captures the
// registered read byte. After reset the same sweep runs with in_ready low.
// One command is in work at a time; in_ready is high only when the sequencer is idle, and a
// finished result waiting on out_ready does not block the next transaction from entering.
`timescale 1ns / 1ps
module mono_framebuffer_draw_engine_top #(
  parameter int SCREEN_WIDTH  = mfde_pkg::DEF_SCREEN_WIDTH,
  parameter int SCREEN_HEIGHT = mfde_pkg::DEF_SCREEN_HEIGHT,
  parameter int STORE_BYTES   = mfde_pkg::DEF_STORE_BYTES
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [2:0] func,
  input  logic [7:0] x_first,
  input  logic [7:0] y_first,
  input  logic [7:0] x_second,
  input  logic [7:0] y_second,
  input  logic [7:0] run_length,
  input  logic       pixel_value,
  input  logic [9:0] byte_index,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] read_data,
  output logic       command_done
);
  import mfde_pkg::*;

  localparam int ADDR_W = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;

  // State and command registers
  state_t            state, state_next;
  func_t             cmd_func;
  logic [7:0]        cmd_xa, cmd_ya, cmd_xb, cmd_yb, cmd_len;
  logic              cmd_val;
  logic [9:0]        cmd_idx;
  logic [7:0]        cur_x, cur_y;
  logic [8:0]        remain;
  logic [1:0]        seg;
  logic [7:0]        col;
  logic [ADDR_W-1:0] clr_addr;
  logic [7:0]        res_data;

  // Store
  logic [7:0]        store [STORE_BYTES];
  logic              mem_we;
  logic [ADDR_W-1:0] mem_addr;
  logic [7:0]        mem_wdata, mem_rdata;

  // Derived combinational values
  logic [7:0]             rect_w, rect_h;
  logic [7:0]             seg_x, seg_y;
  logic [8:0]             seg_len;
  logic                   seg_vert, seg_last, seg_val;
  logic [FULL_ADDR_W-1:0] pix_addr_full, idx_full;
  logic                   pix_on, pix_last, idx_ok, clr_last, accept, out_load;
  logic [7:0]             pix_mask;

  assign accept = in_valid && in_ready;
  assign rect_w = cmd_xb - cmd_xa + 8'd1;
  assign rect_h = cmd_yb - cmd_ya;

  // Segment selection for the command in work
  always_comb begin
    seg_x    = cmd_xa;
    seg_y    = cmd_ya;
    seg_len  = 9'd0;
    seg_vert = 1'b0;
    seg_last = 1'b1;
    seg_val  = 1'b1;
    unique case (cmd_func)
      FUNC_PIXEL: begin
        seg_len = 9'd1;
        seg_val = cmd_val;
      end
      FUNC_HLINE: seg_len = {1'b0, cmd_len};
      FUNC_VLINE: begin
        seg_len  = {1'b0, cmd_len};
        seg_vert = 1'b1;
      end
      FUNC_RECT: begin
        seg_last = (seg == 2'd3);
        unique case (seg)
          2'd0: seg_len = {1'b0, rect_w};
          2'd1: begin
            seg_y   = cmd_yb;
            seg_len = {1'b0, rect_w};
          end
          2'd2: begin
            seg_len  = {1'b0, rect_h};
            seg_vert = 1'b1;
          end
          default: begin
            seg_x    = cmd_xb;
            seg_len  = {1'b0, rect_h};
            seg_vert = 1'b1;
          end
        endcase
      end
      FUNC_FILL: begin
        // one column per segment, h+1 pixels tall; zero width draws nothing
        seg_x    = cmd_xa + col;
        seg_vert = 1'b1;
        if (rect_w == 8'd0) begin
          seg_len  = 9'd0;
          seg_last = 1'b1;
        end else begin
          seg_len  = {1'b0, rect_h} + 9'd1;
          seg_last = (col == rect_w - 8'd1);
        end
      end
      default: ;
    endcase
  end

  // Pixel address and range checks
  assign pix_addr_full = FULL_ADDR_W'(cur_x)
                       + FULL_ADDR_W'(cur_y[7:3]) * FULL_ADDR_W'(SCREEN_WIDTH);
  assign pix_on   = (cur_x < 8'(SCREEN_WIDTH)) && (cur_y < 8'(SCREEN_HEIGHT))
                 && (pix_addr_full < FULL_ADDR_W'(STORE_BYTES));
  assign pix_last = (remain == 9'd1);
  assign pix_mask = 8'd1 << cur_y[2:0];
  assign idx_full = FULL_ADDR_W'(cmd_idx);
  assign idx_ok   = idx_full < FULL_ADDR_W'(STORE_BYTES);
  assign clr_last = (clr_addr == ADDR_W'(STORE_BYTES - 1));

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          priority case (func_t'(func))
            FUNC_CLEAR: state_next = ST_CLEAR;
            FUNC_READ:  state_next = ST_READ;
            FUNC_NOP:   state_next = ST_DONE;
            default:    state_next = ST_SEG;
          endcase
        end
      end
      ST_CLEAR: begin
        if (clr_last) state_next = (cmd_func == FUNC_CLEAR) ? ST_DONE : ST_IDLE;
      end
      ST_SEG: begin
        if (seg_len != 9'd0) state_next = ST_PIX_RD;
        else if (seg_last)   state_next = ST_DONE;
      end
      ST_PIX_RD: begin
        if (pix_on)        state_next = ST_PIX_WR;
        else if (pix_last) state_next = seg_last ? ST_DONE : ST_SEG;
      end
      ST_PIX_WR: begin
        if (pix_last) state_next = seg_last ? ST_DONE : ST_SEG;
        else          state_next = ST_PIX_RD;
      end
      ST_READ:      state_next = idx_ok ? ST_READ_WAIT : ST_DONE;
      ST_READ_WAIT: state_next = ST_DONE;
      ST_DONE: begin
        if (out_load) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer: handshake and store port
  always_comb begin
    in_ready  = (state == ST_IDLE);
    out_load  = (state == ST_DONE) && (!out_valid || out_ready);
    mem_we    = 1'b0;
    mem_addr  = pix_addr_full[ADDR_W-1:0];
    mem_wdata = seg_val ? (mem_rdata | pix_mask) : (mem_rdata & ~pix_mask);
    unique case (state)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_addr  = clr_addr;
        mem_wdata = 8'h00;
      end
      ST_PIX_WR: mem_we = 1'b1;
      ST_READ:   mem_addr = idx_full[ADDR_W-1:0];
      default: ;
    endcase
  end

  // Store: one port, registered read
  always_ff @(posedge clk) begin
    if (mem_we) store[mem_addr] <= mem_wdata;
    mem_rdata <= store[mem_addr];
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_addr  <= '0;
      cmd_func  <= FUNC_NOP;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        cmd_func <= func_t'(func);
        clr_addr <= '0;
      end else if (state == ST_CLEAR) begin
        clr_addr <= clr_addr + ADDR_W'(1);
      end
      if (out_load)                    out_valid <= 1'b1;
      else if (out_valid && out_ready) out_valid <= 1'b0;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_xa   <= x_first;
      cmd_ya   <= y_first;
      cmd_xb   <= x_second;
      cmd_yb   <= y_second;
      cmd_len  <= run_length;
      cmd_val  <= pixel_value;
      cmd_idx  <= byte_index;
      seg      <= 2'd0;
      col      <= 8'd0;
      res_data <= 8'h00;
    end
    // segment setup, or skip an empty one
    if (state == ST_SEG) begin
      if (seg_len == 9'd0) begin
        seg <= seg + 2'd1;
        col <= col + 8'd1;
      end else begin
        cur_x  <= seg_x;
        cur_y  <= seg_y;
        remain <= seg_len;
      end
    end
    // step to the next pixel after a write or an off-screen skip
    if ((state == ST_PIX_WR) || ((state == ST_PIX_RD) && !pix_on)) begin
      if (pix_last) begin
        seg <= seg + 2'd1;
        col <= col + 8'd1;
      end else begin
        remain <= remain - 9'd1;
        if (seg_vert) cur_y <= cur_y + 8'd1;
        else          cur_x <= cur_x + 8'd1;
      end
    end
    if (state == ST_READ_WAIT) res_data <= mem_rdata;
    if (out_load)              read_data <= res_data;
  end

  assign command_done = out_valid;

endmodule

/* rtl/core/mfde_checker.sv */
// Port-level checker for the draw engine, bound to the top level.
`timescale 1ns / 1ps
module mfde_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] read_data
);

  // The clear pass after reset keeps the input closed
  a_reset_busy: assert property (@(posedge clk) rst |=> !in_ready)
    else $error("input ready right after reset");

  // A command keeps the input closed in the cycle after it is accepted
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input ready in the cycle after a transaction");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(read_data))
    else $error("stalled result dropped or changed");

endmodule

bind mono_framebuffer_draw_engine_top mfde_checker u_mfde_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .read_data (read_data)
);
